/* rtl/dwf_pkg.sv */
// Package for the duplicate word filter: sizes, the separator byte, the state
// encoding and the control bundle broadcast to the word cells.
// No dependencies.
package dwf_pkg;

	localparam int MAX_WORDS    = 128;
	localparam int MAX_WORD_LEN = 32;
	localparam int POS_W        = $clog2(MAX_WORD_LEN);
	localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
	localparam int CNT_W        = $clog2(MAX_WORDS + 1);
	localparam int GRP_SIZE     = 8;
	localparam int NUM_GRP      = (MAX_WORDS + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [7:0] SEP_CHAR = 8'd32;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_DECIDE,
		S_SEP,
		S_BYTE,
		S_MARK
	} state_t;

	typedef struct packed {
		logic             byte_en;
		logic             first;
		logic [POS_W-1:0] pos;
		logic [7:0]       char_val;
		logic             len_we;
		logic [LEN_W-1:0] cur_len;
	} cell_ctl_t;

endpackage

/* rtl/dwf_cell.sv */
// One word cell of the filter chain: holds one stored word and its length,
// tracks whether the current word matches it, and passes the hit to its neighbor.
// Depends on dwf_pkg.
module dwf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dwf_pkg::cell_ctl_t ctl,
	input  logic               wsel,
	input  logic               valid,
	input  logic               hit_in,
	output logic               hit_out
);

	logic [7:0]                  word_q [dwf_pkg::MAX_WORD_LEN];
	logic [dwf_pkg::LEN_W-1:0]   len_q;
	logic                        match_q;
	logic                        byte_eq;

	assign byte_eq = (word_q[ctl.pos] == ctl.char_val);

	always_ff @(posedge clk) begin
		if (ctl.byte_en && wsel) begin
			word_q[ctl.pos] <= ctl.char_val;
		end
		if (ctl.len_we && wsel) begin
			len_q <= ctl.cur_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.byte_en) begin
			match_q <= (ctl.first | match_q) & byte_eq;
		end
	end

	// The stored length must agree too, so stale bytes past it never count.
	assign hit_out = hit_in | (valid & match_q & (len_q == ctl.cur_len));

endmodule

/* rtl/duplicate_word_filter_top.sv */
// Top level of the duplicate word filter: word buffer, control sequencer,
// output register and the chain of word cells. Depends on dwf_pkg and dwf_cell.
//
//  channel | signals                                                 | dir
//  --------+---------------------------------------------------------+-----
//  in      | in_valid, in_ready, in_char, in_last                    | in
//  out     | out_valid, out_ready, out_char, char_valid,             | out
//          | end_of_sentence, table_full, word_truncated             |
//
// A byte inside a word is taken while the sequencer is idle. A byte that ends
// a word leads to a compare state, which registers the group hits, and a
// decide state, which combines them; a new word then goes out one item per
// cycle (a separator unless first in its sentence, then its bytes) while the
// output register, which sets the pace, is free. Reset clears the sequencer,
// counters and output valid flag; stored words need no clearing, as only cells
// below the word count are consulted. An output stall holds the emit state.
module duplicate_word_filter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       end_of_sentence,
	output logic       table_full,
	output logic       word_truncated
);

	dwf_pkg::state_t state_q, state_d;

	logic [7:0]                buf_q [dwf_pkg::MAX_WORD_LEN];
	logic [dwf_pkg::LEN_W-1:0] wl_q;
	logic [dwf_pkg::LEN_W-1:0] idx_q;
	logic [dwf_pkg::CNT_W-1:0] count_q;
	logic                      cut_q;
	logic                      last_q;
	logic                      emitted_q;
	logic                      full_q;
	logic [dwf_pkg::NUM_GRP-1:0] grp_s1;

	logic       ov_q;
	logic [7:0] oc_q;
	logic       ocv_q, oeos_q, ofull_q, ocut_q;

	logic in_fire, is_sp, byte_take, word_end, slot_free, seen, room, last_byte;
	logic [dwf_pkg::LEN_W-1:0] new_wl;
	logic       load;
	logic [7:0] ld_char;
	logic       ld_cv, ld_eos, ld_full, ld_cut;

	dwf_pkg::cell_ctl_t ctl;
	logic [dwf_pkg::MAX_WORDS-1:0] hit_out;

	assign in_fire   = in_valid && in_ready;
	assign is_sp     = (in_char == dwf_pkg::SEP_CHAR);
	assign byte_take = !is_sp && (wl_q < dwf_pkg::LEN_W'(dwf_pkg::MAX_WORD_LEN));
	assign new_wl    = wl_q + dwf_pkg::LEN_W'(byte_take);
	assign word_end  = (is_sp || in_last) && (new_wl != '0);
	assign slot_free = !ov_q || out_ready;
	assign seen      = |grp_s1;
	assign room      = (count_q < dwf_pkg::CNT_W'(dwf_pkg::MAX_WORDS));
	assign last_byte = (idx_q == wl_q - dwf_pkg::LEN_W'(1));

	// Control broadcast to every cell; the cell selected by the word count
	// records the current word while it arrives.
	always_comb begin
		ctl.byte_en  = in_fire && byte_take;
		ctl.first    = (wl_q == '0);
		ctl.pos      = wl_q[dwf_pkg::POS_W-1:0];
		ctl.char_val = in_char;
		ctl.len_we   = (state_q == dwf_pkg::S_DECIDE) && !seen && room;
		ctl.cur_len  = wl_q;
	end

	// The cells are grouped; within a group the hit ripples from neighbor to
	// neighbor, and each group result is registered before the final OR.
	genvar gi;
	generate
		for (gi = 0; gi < dwf_pkg::MAX_WORDS; gi++) begin : g_cell
			logic hin;
			if ((gi % dwf_pkg::GRP_SIZE) == 0) begin : g_head
				assign hin = 1'b0;
			end else begin : g_link
				assign hin = hit_out[gi-1];
			end
			dwf_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.wsel    (count_q == dwf_pkg::CNT_W'(gi)),
				.valid   (dwf_pkg::CNT_W'(gi) < count_q),
				.hit_in  (hin),
				.hit_out (hit_out[gi])
			);
			if (((gi % dwf_pkg::GRP_SIZE) == dwf_pkg::GRP_SIZE - 1) ||
			    (gi == dwf_pkg::MAX_WORDS - 1)) begin : g_tail
				always_ff @(posedge clk) begin
					grp_s1[gi / dwf_pkg::GRP_SIZE] <= hit_out[gi];
				end
			end
		end
	endgenerate

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dwf_pkg::S_IDLE: begin
				if (in_fire) begin
					if (word_end) state_d = dwf_pkg::S_CMP;
					else if (in_last) state_d = dwf_pkg::S_MARK;
				end
			end
			dwf_pkg::S_CMP: state_d = dwf_pkg::S_DECIDE;
			dwf_pkg::S_DECIDE: begin
				if (seen) state_d = last_q ? dwf_pkg::S_MARK : dwf_pkg::S_IDLE;
				else if (emitted_q) state_d = dwf_pkg::S_SEP;
				else state_d = dwf_pkg::S_BYTE;
			end
			dwf_pkg::S_SEP: begin
				if (slot_free) state_d = dwf_pkg::S_BYTE;
			end
			dwf_pkg::S_BYTE: begin
				if (slot_free && last_byte) state_d = dwf_pkg::S_IDLE;
			end
			dwf_pkg::S_MARK: begin
				if (slot_free) state_d = dwf_pkg::S_IDLE;
			end
			default: state_d = dwf_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready and the item to load.
	always_comb begin
		in_ready = 1'b0;
		load     = 1'b0;
		ld_char  = 8'd0;
		ld_cv    = 1'b0;
		ld_eos   = 1'b0;
		ld_full  = 1'b0;
		ld_cut   = 1'b0;
		case (state_q)
			dwf_pkg::S_IDLE: in_ready = 1'b1;
			dwf_pkg::S_SEP: begin
				load    = slot_free;
				ld_char = dwf_pkg::SEP_CHAR;
				ld_cv   = 1'b1;
				ld_full = full_q;
				ld_cut  = cut_q;
			end
			dwf_pkg::S_BYTE: begin
				load    = slot_free;
				ld_char = buf_q[idx_q[dwf_pkg::POS_W-1:0]];
				ld_cv   = 1'b1;
				ld_eos  = last_q && last_byte;
				ld_full = full_q;
				ld_cut  = cut_q;
			end
			dwf_pkg::S_MARK: begin
				load   = slot_free;
				ld_eos = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.byte_en) begin
			buf_q[ctl.pos] <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dwf_pkg::S_IDLE;
			wl_q      <= '0;
			idx_q     <= '0;
			count_q   <= '0;
			cut_q     <= 1'b0;
			last_q    <= 1'b0;
			emitted_q <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dwf_pkg::S_IDLE: begin
					if (in_fire) begin
						last_q <= in_last;
						wl_q   <= new_wl;
						if (!is_sp && !byte_take) cut_q <= 1'b1;
					end
				end
				dwf_pkg::S_DECIDE: begin
					idx_q <= '0;
					if (seen) begin
						wl_q  <= '0;
						cut_q <= 1'b0;
					end else begin
						emitted_q <= 1'b1;
						full_q    <= !room;
						if (room) count_q <= count_q + dwf_pkg::CNT_W'(1);
					end
				end
				dwf_pkg::S_BYTE: begin
					if (slot_free) begin
						idx_q <= idx_q + dwf_pkg::LEN_W'(1);
						if (last_byte) begin
							wl_q  <= '0;
							cut_q <= 1'b0;
							if (last_q) begin
								count_q   <= '0;
								emitted_q <= 1'b0;
							end
						end
					end
				end
				dwf_pkg::S_MARK: begin
					if (slot_free) begin
						count_q   <= '0;
						emitted_q <= 1'b0;
						wl_q      <= '0;
						cut_q     <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: holds one item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oc_q    <= ld_char;
			ocv_q   <= ld_cv;
			oeos_q  <= ld_eos;
			ofull_q <= ld_full;
			ocut_q  <= ld_cut;
		end
	end

	assign out_valid       = ov_q;
	assign out_char        = oc_q;
	assign char_valid      = ocv_q;
	assign end_of_sentence = oeos_q;
	assign table_full      = ofull_q;
	assign word_truncated  = ocut_q;

endmodule
